### hw/rtl/binson_stream_tokenizer_assert.svh
// Assertion macros for the Binson stream tokenizer.
`ifndef BINSON_STREAM_TOKENIZER_ASSERT_SVH
`define BINSON_STREAM_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS

// ante high at an edge requires cons at the same edge
`define BST_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed: same-cycle implication");

// ante high at an edge requires cons at the next edge
`define BST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed: next-cycle implication");

`else

`define BST_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define BST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/bst_pkg.sv
// Types, tag codes and helpers shared by the Binson tokenizer.
`default_nettype none
package bst_pkg;

	localparam int MAX_DEPTH   = 16;
	localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
	localparam int STK_W       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int NEST_W      = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] TAG_OBJ_BEGIN = 8'h40;
	localparam logic [7:0] TAG_OBJ_END   = 8'h41;
	localparam logic [7:0] TAG_ARR_BEGIN = 8'h42;
	localparam logic [7:0] TAG_ARR_END   = 8'h43;
	localparam logic [7:0] TAG_TRUE      = 8'h44;
	localparam logic [7:0] TAG_FALSE     = 8'h45;
	localparam logic [7:0] TAG_DOUBLE    = 8'h46;
	localparam logic [7:0] TAG_INT8      = 8'h10;
	localparam logic [7:0] TAG_INT64     = 8'h13;
	localparam logic [7:0] TAG_STR8      = 8'h14;
	localparam logic [7:0] TAG_STR32     = 8'h16;
	localparam logic [7:0] TAG_BYTES8    = 8'h18;
	localparam logic [7:0] TAG_BYTES32   = 8'h1a;

	localparam logic KIND_OBJ = 1'b0;
	localparam logic KIND_ARR = 1'b1;

	typedef enum logic [3:0] {
		TK_OBJ_OPEN  = 4'd0,
		TK_OBJ_CLOSE = 4'd1,
		TK_ARR_OPEN  = 4'd2,
		TK_ARR_CLOSE = 4'd3,
		TK_NAME_LEN  = 4'd4,
		TK_STR_LEN   = 4'd5,
		TK_BYTES_LEN = 4'd6,
		TK_PAYLOAD   = 4'd7,
		TK_INT       = 4'd8,
		TK_DOUBLE    = 4'd9,
		TK_BOOL      = 4'd10,
		TK_ERROR     = 4'd11
	} tok_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_BAD_TAG  = 3'd1,
		ERR_TRUNC    = 3'd2,
		ERR_NEG_LEN  = 3'd3,
		ERR_TOO_DEEP = 3'd4,
		ERR_TRAILING = 3'd5
	} err_code_t;

	// token as it travels from the parser through the queue
	typedef struct packed {
		tok_kind_t          kind;
		logic [63:0]        value;
		logic [NEST_W-1:0]  depth;
		err_code_t          err;
		logic               last;
		logic               done;
		logic               sext;
		logic [1:0]         size_log2;
	} tok_t;

	function automatic logic is_int_tag(input logic [7:0] t);
		return (t >= TAG_INT8) && (t <= TAG_INT64);
	endfunction

	function automatic logic is_str_tag(input logic [7:0] t);
		return (t >= TAG_STR8) && (t <= TAG_STR32);
	endfunction

	function automatic logic is_bytes_tag(input logic [7:0] t);
		return (t >= TAG_BYTES8) && (t <= TAG_BYTES32);
	endfunction

	// log2 of the number of bytes that follow a numeric or length tag
	function automatic logic [1:0] size_log2(input logic [7:0] t);
		logic [1:0] r;
		if (is_int_tag(t) || is_str_tag(t) || is_bytes_tag(t)) begin
			r = t[1:0];
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/bst_stream_if.sv
// Valid/ready channel interfaces for raw document bytes and tokens.
`default_nettype none
interface bst_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       end_of_buffer;

	modport source(output valid, data_byte, first_byte, end_of_buffer, input ready);
	modport sink(input valid, data_byte, first_byte, end_of_buffer, output ready);
endinterface

interface bst_token_if;
	logic               valid;
	logic               ready;
	logic [3:0]         token_kind;
	logic signed [63:0] token_value;
	logic [4:0]         nest_depth;
	logic [2:0]         error_code;
	logic               last_payload;
	logic               document_done;

	modport source(output valid, token_kind, token_value, nest_depth, error_code,
		last_payload, document_done, input ready);
	modport sink(input valid, token_kind, token_value, nest_depth, error_code,
		last_payload, document_done, output ready);
endinterface
`default_nettype wire

### hw/rtl/bst_front.sv
// Front end: a byte a cycle unless q_full; tracks nesting, emits raw tokens.
`default_nettype none
module bst_front (
	input  wire         clk,
	input  wire         arst_n,
	bst_byte_if.sink    byte_in,
	input  wire         q_full,
	output logic        push,
	output bst_pkg::tok_t push_tok
);
	import bst_pkg::*;

	typedef enum logic [3:0] {
		PH_OPEN, PH_ITEM, PH_VALUE, PH_NAMENUM, PH_NUM,
		PH_NAMEPAY, PH_PAY, PH_DONE, PH_ERR
	} phase_t;

	phase_t               phase_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [7:0]           tag_q;
	logic [3:0]           left_q;
	logic [63:0]          acc_q;
	logic [31:0]          remain_q;
	logic                 kinds_q [MAX_DEPTH];

	phase_t               ph, ph_n;
	logic [DEPTH_W-1:0]   dep, dep_n, top_idx;
	logic [7:0]           tag, tag_n, b;
	logic [3:0]           left, left_n, total;
	logic [63:0]          acc, acc_n, acc_asm;
	logic [31:0]          rem, rem_n;
	logic [2:0]           idx;
	logic                 top_kind, accept;
	logic                 open_req, open_kind, close_req, close_kind;
	logic                 value_req, num_req, num_name, bad;
	logic                 stk_we, stk_wkind;
	tok_t                 tok;
	logic                 emit;

	assign accept       = byte_in.valid && byte_in.ready;
	assign byte_in.ready = !q_full;
	assign b            = byte_in.data_byte;

	always_comb begin
		// a first byte restarts the parse before the byte is taken
		ph   = byte_in.first_byte ? PH_OPEN : phase_q;
		dep  = byte_in.first_byte ? '0 : depth_q;
		tag  = byte_in.first_byte ? '0 : tag_q;
		left = byte_in.first_byte ? '0 : left_q;
		acc  = byte_in.first_byte ? '0 : acc_q;
		rem  = byte_in.first_byte ? '0 : remain_q;

		top_idx  = dep - DEPTH_W'(1);
		top_kind = (dep == '0) ? KIND_OBJ : kinds_q[top_idx[STK_W-1:0]];
		total    = 4'd1 << size_log2(tag);
		idx      = 3'(total - left);
		acc_asm  = acc | (64'(b) << {idx, 3'b000});

		ph_n = ph; dep_n = dep; tag_n = tag; left_n = left; acc_n = acc; rem_n = rem;
		open_req = 1'b0; open_kind = KIND_OBJ; close_req = 1'b0; close_kind = KIND_OBJ;
		value_req = 1'b0; num_req = 1'b0; num_name = 1'b0; bad = 1'b0;
		stk_we = 1'b0; stk_wkind = KIND_OBJ;
		emit = 1'b0;
		tok = '0;
		tok.kind = TK_ERROR;
		tok.err  = ERR_NONE;

		case (ph)
			PH_OPEN: begin
				if (b == TAG_OBJ_BEGIN) open_req = 1'b1;
				else bad = 1'b1;
			end
			PH_ITEM: begin
				if (top_kind == KIND_OBJ) begin
					if (b == TAG_OBJ_END) begin
						close_req = 1'b1;
					end else if (is_str_tag(b)) begin
						num_req  = 1'b1;
						num_name = 1'b1;
					end else begin
						bad = 1'b1;
					end
				end else begin
					if (b == TAG_ARR_END) begin
						close_req  = 1'b1;
						close_kind = KIND_ARR;
					end else begin
						value_req = 1'b1;
					end
				end
			end
			PH_VALUE: value_req = 1'b1;
			PH_NAMENUM, PH_NUM: begin
				acc_n  = acc_asm;
				left_n = left - 4'(left != 4'd0);
				if (left_n == 4'd0) begin
					emit = 1'b1;
					tok.value = acc_asm;
					if (tag == TAG_DOUBLE) begin
						tok.kind = TK_DOUBLE;
						ph_n = PH_ITEM;
					end else if (is_int_tag(tag)) begin
						tok.kind      = TK_INT;
						tok.sext      = 1'b1;
						tok.size_log2 = size_log2(tag);
						ph_n = PH_ITEM;
					end else if (b[7]) begin
						// top byte carries the sign of a length
						tok.err = ERR_NEG_LEN;
					end else begin
						if (ph == PH_NAMENUM) tok.kind = TK_NAME_LEN;
						else if (tag <= TAG_STR32) tok.kind = TK_STR_LEN;
						else tok.kind = TK_BYTES_LEN;
						rem_n = acc_asm[31:0];
						if (acc_asm == '0) ph_n = (ph == PH_NAMENUM) ? PH_VALUE : PH_ITEM;
						else ph_n = (ph == PH_NAMENUM) ? PH_NAMEPAY : PH_PAY;
					end
				end
			end
			PH_NAMEPAY, PH_PAY: begin
				emit = 1'b1;
				tok.kind  = TK_PAYLOAD;
				tok.value = 64'(b);
				rem_n = rem - 32'(rem != '0);
				if (rem_n == '0) begin
					tok.last = 1'b1;
					ph_n = (ph == PH_NAMEPAY) ? PH_VALUE : PH_ITEM;
				end
			end
			PH_DONE: tok.err = ERR_TRAILING;
			default: ;
		endcase

		if (value_req) begin
			if (b == TAG_OBJ_BEGIN) begin
				open_req = 1'b1;
			end else if (b == TAG_ARR_BEGIN) begin
				open_req  = 1'b1;
				open_kind = KIND_ARR;
			end else if (b == TAG_TRUE || b == TAG_FALSE) begin
				emit = 1'b1;
				tok.kind  = TK_BOOL;
				tok.value = 64'(b == TAG_TRUE);
				ph_n = PH_ITEM;
			end else if (b == TAG_DOUBLE || is_int_tag(b) || is_str_tag(b) ||
					is_bytes_tag(b)) begin
				num_req = 1'b1;
			end else begin
				bad = 1'b1;
			end
		end

		if (open_req) begin
			if (dep >= DEPTH_W'(MAX_DEPTH)) begin
				tok.err = ERR_TOO_DEEP;
			end else begin
				stk_we    = 1'b1;
				stk_wkind = open_kind;
				dep_n     = dep + DEPTH_W'(1);
				emit      = 1'b1;
				tok.kind  = (open_kind == KIND_ARR) ? TK_ARR_OPEN : TK_OBJ_OPEN;
				ph_n      = PH_ITEM;
			end
		end

		if (close_req) begin
			dep_n    = dep - DEPTH_W'(dep != '0);
			emit     = 1'b1;
			tok.kind = (close_kind == KIND_ARR) ? TK_ARR_CLOSE : TK_OBJ_CLOSE;
			if (dep_n == '0) begin
				ph_n     = PH_DONE;
				tok.done = 1'b1;
			end else begin
				ph_n = PH_ITEM;
			end
		end

		if (num_req) begin
			tag_n  = b;
			left_n = 4'd1 << size_log2(b);
			acc_n  = '0;
			ph_n   = num_name ? PH_NAMENUM : PH_NUM;
		end

		if (bad) tok.err = ERR_BAD_TAG;
		if (tok.err == ERR_NONE && byte_in.end_of_buffer && ph_n != PH_DONE)
			tok.err = ERR_TRUNC;
		if (tok.err != ERR_NONE) begin
			ph_n = PH_ERR;
			emit = 1'b1;
			tok.kind  = TK_ERROR;
			tok.value = '0;
			tok.last  = 1'b0;
			tok.done  = 1'b0;
			tok.sext  = 1'b0;
		end

		// a latched error swallows every byte until the next restart
		if (ph == PH_ERR) begin
			emit = 1'b0;
			ph_n = PH_ERR;
			stk_we = 1'b0;
		end

		tok.depth = NEST_W'(dep_n);
	end

	assign push     = accept && emit;
	assign push_tok = tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPEN;
			depth_q  <= '0;
			tag_q    <= '0;
			left_q   <= '0;
			acc_q    <= '0;
			remain_q <= '0;
		end else if (accept) begin
			phase_q  <= ph_n;
			depth_q  <= dep_n;
			tag_q    <= tag_n;
			left_q   <= left_n;
			acc_q    <= acc_n;
			remain_q <= rem_n;
		end
	end

	// container stack, no reset: only entries below the depth are read
	always_ff @(posedge clk) begin
		if (accept && stk_we) begin
			kinds_q[dep[STK_W-1:0]] <= stk_wkind;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bst_queue.sv
// Short token queue between the parser and the output stage.
`default_nettype none
module bst_queue (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push,
	input  bst_pkg::tok_t din,
	output logic          full,
	input  wire           pop,
	output bst_pkg::tok_t dout,
	output logic          empty
);
	import bst_pkg::*;

	tok_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			count_q <= count_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
		end
	end

endmodule
`default_nettype wire

### hw/rtl/bst_back.sv
// Output stage: sign-extends numbers and holds the token word for the receiver.
`default_nettype none
module bst_back (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           q_empty,
	input  bst_pkg::tok_t q_tok,
	output logic          pop,
	bst_token_if.source   token_out
);
	import bst_pkg::*;

	logic        valid_q;
	tok_t        tok_q;
	tok_t        ext_tok;

	assign pop = !q_empty && (!valid_q || token_out.ready);

	always_comb begin
		ext_tok = q_tok;
		if (q_tok.sext) begin
			case (q_tok.size_log2)
				2'd0:    ext_tok.value = {{56{q_tok.value[7]}}, q_tok.value[7:0]};
				2'd1:    ext_tok.value = {{48{q_tok.value[15]}}, q_tok.value[15:0]};
				2'd2:    ext_tok.value = {{32{q_tok.value[31]}}, q_tok.value[31:0]};
				default: ext_tok.value = q_tok.value;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (token_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tok_q <= ext_tok;
		end
	end

	assign token_out.valid         = valid_q;
	assign token_out.token_kind    = tok_q.kind;
	assign token_out.token_value   = $signed(tok_q.value);
	assign token_out.nest_depth    = tok_q.depth;
	assign token_out.error_code    = tok_q.err;
	assign token_out.last_payload  = tok_q.last;
	assign token_out.document_done = tok_q.done;

endmodule
`default_nettype wire

### hw/rtl/binson_stream_tokenizer.sv
// Binson stream tokenizer top level: parser, token queue and output stage.
//
// byte_in takes one document byte per word with first_byte (restart the
// parser before this byte) and end_of_buffer (last byte of the buffer).
// token_out gives at most one token per byte: kind, value, nesting depth,
// error code, last-payload and document-done flags. The tag byte and the
// leading bytes of a number or length give no token.
// Throughput is one byte per cycle while the queue is not full; every byte is
// classified combinationally by the parser state machine. A token is written
// to the queue at the edge that takes its byte and reaches token_out once the
// output register loads it from the queue, which waits while token_out stalls.
// A four-word queue sits between the parser and the output register, so
// byte_in.ready depends only on the queue fill; when the receiver stalls the
// queue fills and byte_in.ready drops once it holds four tokens.
// After an error token every byte is taken and dropped until first_byte.
// Reset clears the parser to expect a document open and empties the queue;
// the container stack is not cleared and needs no clearing pass.
`default_nettype none
module binson_stream_tokenizer (
	input  wire          clk,
	input  wire          arst_n,
	bst_byte_if.sink     byte_in,
	bst_token_if.source  token_out
);
	import bst_pkg::*;

	`include "binson_stream_tokenizer_assert.svh"

	logic push, q_full, q_empty, pop;
	tok_t push_tok, q_tok;

	bst_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.q_full   (q_full),
		.push     (push),
		.push_tok (push_tok)
	);

	bst_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_tok),
		.full   (q_full),
		.pop    (pop),
		.dout   (q_tok),
		.empty  (q_empty)
	);

	bst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_tok     (q_tok),
		.pop       (pop),
		.token_out (token_out)
	);

	`BST_ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push, !q_full)
	`BST_ASSERT_NEXT(a_pop_shows, clk, arst_n, pop, token_out.valid)
	`BST_ASSERT_IMPLIES(a_done_close, clk, arst_n, token_out.valid && token_out.document_done, token_out.token_kind == TK_OBJ_CLOSE && token_out.nest_depth == '0)
	`BST_ASSERT_IMPLIES(a_err_code, clk, arst_n, token_out.valid && token_out.token_kind == TK_ERROR, token_out.error_code != ERR_NONE && token_out.token_value == '0)

endmodule
`default_nettype wire
